// ----- hdl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, codes, types and helpers of the district seat allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_PARTIES  = 32;
    localparam int MIN_PARTIES  = 2;
    localparam int PARTY_W      = $clog2(MAX_PARTIES);

    localparam int COUNT_W      = 6;
    localparam int VOTE_W       = 32;
    localparam int SEAT_W       = 8;
    localparam int CNT_W        = 16;
    localparam int TVOTE_W      = 48;
    localparam int IDX_W        = 5;
    localparam int ALLOC_W      = SEAT_W + VOTE_W;
    localparam int CNT_SUM_W    = CNT_W + 1;
    localparam int TVOTE_SUM_W  = TVOTE_W + 1;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [COUNT_W-1:0]   PARTY_COUNT_RESET = COUNT_W'(MIN_PARTIES);
    localparam logic [PADDR_W-3:0]   REG_PARTY_COUNT   = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_AWARD,
        ST_OUT_RD,
        ST_OUT_EMIT
    } dsa_state_t;

    typedef struct packed {
        logic take_item;
        logic clear_best;
        logic scan_rd;
        logic award;
        logic out_rd;
        logic emit;
    } dsa_cmd_t;

    typedef struct packed {
        logic last_item;
        logic quota_zero;
        logic rd_last;
        logic found;
        logic seats_done;
        logic out_free;
        logic emit_last;
    } dsa_status_t;

    typedef struct packed {
        logic [CNT_W-1:0]   seats;
        logic [TVOTE_W-1:0] votes;
        logic [CNT_W-1:0]   firsts;
        logic [CNT_W-1:0]   zeros;
    } dsa_tally_t;

    // Index of the last party, with the party count clamped to its legal range.
    function automatic logic [PARTY_W-1:0] last_party(input logic [COUNT_W-1:0] count);
        logic [PARTY_W-1:0] r;
        if (int'(count) < MIN_PARTIES)
        begin
            r = PARTY_W'(MIN_PARTIES - 1);
        end
        else if (int'(count) > MAX_PARTIES)
        begin
            r = PARTY_W'(MAX_PARTIES - 1);
        end
        else
        begin
            r = PARTY_W'(count - COUNT_W'(1));
        end
        return r;
    endfunction

endpackage

// ----- hdl/dsa_item_if.sv -----
// ----------------------------------------------------------------------------
// dsa_item_if
// Vote item channel: one party's votes and the district seat quota.
// ----------------------------------------------------------------------------
interface dsa_item_if;
    logic                                valid;
    logic                                ready;
    logic [dsa_pkg::VOTE_W-1:0]          votes;
    logic [dsa_pkg::SEAT_W-1:0]          district_seats;

    modport source (output valid, output votes, output district_seats, input ready);
    modport sink   (input valid, input votes, input district_seats, output ready);
endinterface

// ----- hdl/dsa_result_if.sv -----
// ----------------------------------------------------------------------------
// dsa_result_if
// Result channel: one party's district seats and national totals.
// ----------------------------------------------------------------------------
interface dsa_result_if;
    logic                                valid;
    logic                                ready;
    logic [dsa_pkg::IDX_W-1:0]           party_index;
    logic [dsa_pkg::SEAT_W-1:0]          seats_won;
    logic [dsa_pkg::CNT_W-1:0]           total_seats;
    logic [dsa_pkg::TVOTE_W-1:0]         total_votes;
    logic [dsa_pkg::CNT_W-1:0]           districts_first;
    logic [dsa_pkg::CNT_W-1:0]           districts_no_seat;
    logic                                last_result;

    modport source (output valid, output party_index, output seats_won, output total_seats,
                    output total_votes, output districts_first, output districts_no_seat,
                    output last_result, input ready);
    modport sink   (input valid, input party_index, input seats_won, input total_seats,
                    input total_votes, input districts_first, input districts_no_seat,
                    input last_result, output ready);
endinterface

// ----- hdl/dsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: takes items, runs one quotient scan per seat, then emits results.
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dsa_pkg::dsa_status_t status,
    output dsa_pkg::dsa_cmd_t    cmd
);

    dsa_pkg::dsa_state_t state_reg;
    dsa_pkg::dsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            dsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (status.last_item)
                    begin
                        cmd.clear_best = 1'b1;
                        state_next = status.quota_zero ? dsa_pkg::ST_OUT_RD : dsa_pkg::ST_SCAN;
                    end
                end
            end
            dsa_pkg::ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.rd_last)
                begin
                    state_next = dsa_pkg::ST_SCAN_TAIL;
                end
            end
            dsa_pkg::ST_SCAN_TAIL:
            begin
                state_next = dsa_pkg::ST_AWARD;
            end
            dsa_pkg::ST_AWARD:
            begin
                cmd.award      = 1'b1;
                cmd.clear_best = 1'b1;
                if (!status.found || status.seats_done)
                begin
                    state_next = dsa_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = dsa_pkg::ST_SCAN;
                end
            end
            dsa_pkg::ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = dsa_pkg::ST_OUT_EMIT;
            end
            dsa_pkg::ST_OUT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.emit_last ? dsa_pkg::ST_IDLE : dsa_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = dsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/dsa_datapath.sv -----
// ----------------------------------------------------------------------------
// dsa_datapath
// Per-district stores, quotient maximum search, national tally and output.
// ----------------------------------------------------------------------------
module dsa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [dsa_pkg::COUNT_W-1:0]        cfg_data,
    output logic [dsa_pkg::COUNT_W-1:0]        party_count,
    input  logic [dsa_pkg::VOTE_W-1:0]         votes,
    input  logic [dsa_pkg::SEAT_W-1:0]         district_seats,
    input  dsa_pkg::dsa_cmd_t                  cmd,
    output dsa_pkg::dsa_status_t               status,
    dsa_result_if.source                       results
);

    // Configuration and control registers.
    logic [dsa_pkg::COUNT_W-1:0]   party_count_reg;
    logic [dsa_pkg::PARTY_W-1:0]   pos_reg;
    logic [dsa_pkg::PARTY_W-1:0]   rd_addr_reg;
    logic                          cmp_valid_reg;
    logic                          found_reg;
    logic                          nat_rd_valid_reg;
    logic [dsa_pkg::MAX_PARTIES-1:0] nat_valid_reg;
    logic                          out_valid_reg;

    // Payload registers.
    logic [dsa_pkg::PARTY_W-1:0]   cmp_idx_reg;
    logic [dsa_pkg::VOTE_W-1:0]    best_q_reg;
    logic [dsa_pkg::SEAT_W-1:0]    best_seat_reg;
    logic [dsa_pkg::PARTY_W-1:0]   best_idx_reg;
    logic [dsa_pkg::SEAT_W-1:0]    quota_reg;
    logic [dsa_pkg::SEAT_W-1:0]    seat_cnt_reg;
    logic [dsa_pkg::PARTY_W-1:0]   first_idx_reg;
    logic [dsa_pkg::VOTE_W-1:0]    first_votes_reg;
    logic [dsa_pkg::ALLOC_W-1:0]   alloc_rd_reg;
    logic [dsa_pkg::VOTE_W-1:0]    vote_rd_reg;
    dsa_pkg::dsa_tally_t           nat_rd_reg;
    logic [dsa_pkg::PARTY_W-1:0]   emit_idx_reg;

    logic [dsa_pkg::IDX_W-1:0]     out_idx_reg;
    logic [dsa_pkg::SEAT_W-1:0]    out_seats_reg;
    dsa_pkg::dsa_tally_t           out_tally_reg;
    logic                          out_last_reg;

    // Memories: seat count and quotient share a word, so one scan reads both.
    logic [dsa_pkg::ALLOC_W-1:0]   alloc_mem [dsa_pkg::MAX_PARTIES];
    logic [dsa_pkg::VOTE_W-1:0]    vote_mem  [dsa_pkg::MAX_PARTIES];
    dsa_pkg::dsa_tally_t           nat_mem   [dsa_pkg::MAX_PARTIES];

    logic [dsa_pkg::PARTY_W-1:0]   last_idx;
    logic [dsa_pkg::VOTE_W-1:0]    cmp_q;
    logic [dsa_pkg::SEAT_W-1:0]    cmp_seat;
    logic                          alloc_we;
    logic [dsa_pkg::PARTY_W-1:0]   alloc_wa;
    logic [dsa_pkg::ALLOC_W-1:0]   alloc_wd;
    logic [dsa_pkg::SEAT_W-1:0]    emit_seat;
    dsa_pkg::dsa_tally_t           tally_old;
    dsa_pkg::dsa_tally_t           tally_new;
    logic [dsa_pkg::CNT_SUM_W-1:0]   seat_sum;
    logic [dsa_pkg::TVOTE_SUM_W-1:0] vote_sum;
    logic [dsa_pkg::CNT_SUM_W-1:0]   first_sum;
    logic [dsa_pkg::CNT_SUM_W-1:0]   zero_sum;

    assign last_idx    = dsa_pkg::last_party(party_count_reg);
    assign party_count = party_count_reg;
    assign cmp_q       = alloc_rd_reg[dsa_pkg::VOTE_W-1:0];
    assign cmp_seat    = alloc_rd_reg[dsa_pkg::ALLOC_W-1 -: dsa_pkg::SEAT_W];
    assign emit_seat   = cmp_seat;

    assign status.last_item  = pos_reg >= last_idx;
    assign status.quota_zero = district_seats == '0;
    assign status.rd_last    = rd_addr_reg == last_idx;
    assign status.found      = found_reg;
    assign status.seats_done = (seat_cnt_reg + dsa_pkg::SEAT_W'(1)) == quota_reg;
    assign status.out_free   = !out_valid_reg || results.ready;
    assign status.emit_last  = emit_idx_reg == last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            party_count_reg  <= dsa_pkg::PARTY_COUNT_RESET;
            pos_reg          <= '0;
            rd_addr_reg      <= '0;
            cmp_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            nat_rd_valid_reg <= 1'b0;
            nat_valid_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                party_count_reg <= cfg_data;
                pos_reg         <= '0;
            end
            else if (cmd.take_item)
            begin
                pos_reg <= status.last_item ? '0 : pos_reg + dsa_pkg::PARTY_W'(1);
            end

            if (cmd.clear_best)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.scan_rd || cmd.out_rd)
            begin
                rd_addr_reg <= rd_addr_reg + dsa_pkg::PARTY_W'(1);
            end

            cmp_valid_reg <= cmd.scan_rd;

            if (cmd.clear_best)
            begin
                found_reg <= 1'b0;
            end
            else if (cmp_valid_reg && (cmp_q > best_q_reg))
            begin
                found_reg <= 1'b1;
            end

            if (cmd.out_rd)
            begin
                nat_rd_valid_reg <= nat_valid_reg[rd_addr_reg];
            end

            if (cmd.emit)
            begin
                nat_valid_reg[emit_idx_reg] <= 1'b1;
                out_valid_reg               <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Running maximum over one scan; a strict compare keeps the lowest index on ties.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_best)
        begin
            best_q_reg <= '0;
        end
        else if (cmp_valid_reg && (cmp_q > best_q_reg))
        begin
            best_q_reg    <= cmp_q;
            best_seat_reg <= cmp_seat;
            best_idx_reg  <= cmp_idx_reg;
        end
        cmp_idx_reg <= rd_addr_reg;

        if (cmd.take_item)
        begin
            quota_reg    <= district_seats;
            seat_cnt_reg <= '0;
            if ((pos_reg == '0) || (votes > first_votes_reg))
            begin
                first_idx_reg   <= pos_reg;
                first_votes_reg <= votes;
            end
        end
        else if (cmd.award && found_reg)
        begin
            seat_cnt_reg <= seat_cnt_reg + dsa_pkg::SEAT_W'(1);
        end

        if (cmd.out_rd)
        begin
            emit_idx_reg <= rd_addr_reg;
        end

        if (cmd.emit)
        begin
            out_idx_reg   <= dsa_pkg::IDX_W'(emit_idx_reg);
            out_seats_reg <= emit_seat;
            out_tally_reg <= tally_new;
            out_last_reg  <= status.emit_last;
        end
    end

    // The winner's quotient is halved as it takes a seat.
    always_comb
    begin
        alloc_we = 1'b0;
        alloc_wa = pos_reg;
        alloc_wd = {dsa_pkg::SEAT_W'(0), votes};
        if (cmd.take_item)
        begin
            alloc_we = 1'b1;
        end
        else if (cmd.award && found_reg)
        begin
            alloc_we = 1'b1;
            alloc_wa = best_idx_reg;
            alloc_wd = {best_seat_reg + dsa_pkg::SEAT_W'(1), best_q_reg >> 1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[alloc_wa] <= alloc_wd;
        end
        if (cmd.scan_rd || cmd.out_rd)
        begin
            alloc_rd_reg <= alloc_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            vote_mem[pos_reg] <= votes;
        end
        if (cmd.out_rd)
        begin
            vote_rd_reg <= vote_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            nat_mem[emit_idx_reg] <= tally_new;
        end
        if (cmd.out_rd)
        begin
            nat_rd_reg <= nat_mem[rd_addr_reg];
        end
    end

    // Saturating update of one party's national totals.
    always_comb
    begin
        tally_old = nat_rd_valid_reg ? nat_rd_reg : '0;
        seat_sum  = {1'b0, tally_old.seats} + dsa_pkg::CNT_SUM_W'(emit_seat);
        vote_sum  = {1'b0, tally_old.votes} + dsa_pkg::TVOTE_SUM_W'(vote_rd_reg);
        first_sum = {1'b0, tally_old.firsts}
                  + dsa_pkg::CNT_SUM_W'(emit_idx_reg == first_idx_reg);
        zero_sum  = {1'b0, tally_old.zeros} + dsa_pkg::CNT_SUM_W'(emit_seat == '0);
        tally_new.seats  = seat_sum[dsa_pkg::CNT_W] ? '1 : seat_sum[dsa_pkg::CNT_W-1:0];
        tally_new.votes  = vote_sum[dsa_pkg::TVOTE_W] ? '1 : vote_sum[dsa_pkg::TVOTE_W-1:0];
        tally_new.firsts = first_sum[dsa_pkg::CNT_W] ? '1 : first_sum[dsa_pkg::CNT_W-1:0];
        tally_new.zeros  = zero_sum[dsa_pkg::CNT_W] ? '1 : zero_sum[dsa_pkg::CNT_W-1:0];
    end

    assign results.valid             = out_valid_reg;
    assign results.party_index       = out_idx_reg;
    assign results.seats_won         = out_seats_reg;
    assign results.total_seats       = out_tally_reg.seats;
    assign results.total_votes       = out_tally_reg.votes;
    assign results.districts_first   = out_tally_reg.firsts;
    assign results.districts_no_seat = out_tally_reg.zeros;
    assign results.last_result       = out_last_reg;

`ifndef SYNTHESIS
    // A seat is only ever awarded to a positive quotient.
    a_found_positive: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_q_reg != '0))
        else $error("winner recorded with a zero quotient");

    // No seat beyond the district quota is handed out.
    a_quota_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.award && found_reg) |-> (seat_cnt_reg < quota_reg))
        else $error("seat awarded past the district quota");

    // A scan never reads past the last active party.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (rd_addr_reg <= last_idx))
        else $error("quotient scan beyond the last party");

    // A new result never overwrites one that is still waiting.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || results.ready))
        else $error("result register overwritten");

    // Results of a district are emitted only after its input position wrapped.
    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (pos_reg == '0))
        else $error("results emitted while a district is still arriving");
`endif

endmodule

// ----- hdl/district_seat_allocator_with_tally.sv -----
// ----------------------------------------------------------------------------
// district_seat_allocator_with_tally
// Highest-averages seat allocation per district with running national totals.
// ----------------------------------------------------------------------------
// Feed one vote item per party, in party order; items before the last party
// are taken back to back. The last party's item starts the allocation, and
// the seat quota on that item is the one used. Each seat costs one scan of the
// stored quotients through a single-port memory, one party per cycle, then
// the scan tail and award states; allocation stops early when every quotient
// reaches zero. The winner of a seat has its quotient halved. Then one result
// per party leaves in party order through the read and emit states, carrying
// the district seats and that party's saturating national totals; the final
// result is flagged with last_result. No new item is taken until the last
// result of a district has been loaded into the output register, but the block
// takes the next district's items while that result still waits for its
// transfer. National counters are cleared by valid bits at reset, so no
// clearing pass is needed. Writing party_count restarts the district at party
// 0; values outside 2 to the maximum party count are stored as written and
// used clamped.
module district_seat_allocator_with_tally (
    input  logic                           clk,
    input  logic                           rst_n,
    dsa_item_if.sink                       items,
    dsa_result_if.source                   results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsa_pkg::PADDR_W-1:0]    paddr,
    input  logic [dsa_pkg::PDATA_W-1:0]    pwdata,
    output logic [dsa_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    dsa_pkg::dsa_cmd_t              cmd;
    dsa_pkg::dsa_status_t           status;
    logic                           cfg_sel;
    logic                           cfg_wr;
    logic [dsa_pkg::COUNT_W-1:0]    party_count;

    // The single register sits at word zero; other words read as zero and
    // ignore writes.
    assign cfg_sel = paddr[dsa_pkg::PADDR_W-1:2] == dsa_pkg::REG_PARTY_COUNT;
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? dsa_pkg::PDATA_W'(party_count) : '0;

    dsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dsa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_wr),
        .cfg_data       (pwdata[dsa_pkg::COUNT_W-1:0]),
        .party_count    (party_count),
        .votes          (items.votes),
        .district_seats (items.district_seats),
        .cmd            (cmd),
        .status         (status),
        .results        (results)
    );

endmodule

// ----- bench/tb_district_seat_allocator_with_tally.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_district_seat_allocator_with_tally
// Self-checking bench for the district seat allocator with national tally.
// Districts of vote items go in through a queue-fed driver. A shadow of the
// seat allocation and the national counters predicts every party result, and
// a monitor checks each result transfer against it. Phases change the party
// count and the idle pattern of both channels.
// ----------------------------------------------------------------------------
module tb_district_seat_allocator_with_tally;

    import dsa_pkg::*;

    // Register map: the party count sits at register 0. Register 1 does not
    // exist, so a write there must leave everything alone.
    localparam logic [PADDR_W-1:0] ADDR_PARTY_COUNT = {REG_PARTY_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = {~REG_PARTY_COUNT, 2'b00};

    // The longest silent stretch of a correct run is the allocation of one
    // district of 32 parties with a quota of 255, with no transfer at all. The
    // limit allows several times that.
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 200;

    typedef struct packed {
        logic [VOTE_W-1:0] votes;
        logic [SEAT_W-1:0] quota;
    } ballot_t;

    typedef struct packed {
        logic [IDX_W-1:0]   party;
        logic [SEAT_W-1:0]  seats;
        logic [CNT_W-1:0]   total_seats;
        logic [TVOTE_W-1:0] total_votes;
        logic [CNT_W-1:0]   firsts;
        logic [CNT_W-1:0]   no_seat;
        logic               last;
    } party_tally_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every input of the block is a bench variable with a known start value.
    logic               item_valid = 1'b0;
    logic [VOTE_W-1:0]  item_votes = '0;
    logic [SEAT_W-1:0]  item_quota = '0;
    logic               res_ready  = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dsa_item_if   item_ch ();
    dsa_result_if result_ch ();

    assign item_ch.valid          = item_valid;
    assign item_ch.votes          = item_votes;
    assign item_ch.district_seats = item_quota;
    assign result_ch.ready        = res_ready;

    district_seat_allocator_with_tally u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Percentages of cycles in which the vote source holds back and the
    // result sink stalls. They change only at falling edges between phases.
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    ballot_t      ballot_queue [$];
    party_tally_t due_tallies  [$];

    int result_errors   = 0;
    int register_errors = 0;
    int random_items    = 0;
    int quiet_cycles    = 0;

    // Shadow of the block state. Only the driver process updates it, both for
    // accepted vote items and for register writes seen on the bus.
    logic [COUNT_W-1:0] count_shadow = PARTY_COUNT_RESET;
    int                 seat_position = 0;
    logic [VOTE_W-1:0]  dist_votes [MAX_PARTIES];
    logic [VOTE_W-1:0]  dist_quot  [MAX_PARTIES];
    logic [SEAT_W-1:0]  dist_seats [MAX_PARTIES];
    logic [CNT_W-1:0]   nat_seats  [MAX_PARTIES] = '{default: '0};
    logic [TVOTE_W-1:0] nat_votes  [MAX_PARTIES] = '{default: '0};
    logic [CNT_W-1:0]   nat_firsts [MAX_PARTIES] = '{default: '0};
    logic [CNT_W-1:0]   nat_noseat [MAX_PARTIES] = '{default: '0};

    // The party count in use is the register value clamped to 2..MAX_PARTIES.
    function automatic int live_parties(input logic [COUNT_W-1:0] count);
        int n;
        n = int'(count);
        if (n < MIN_PARTIES)
        begin
            n = MIN_PARTIES;
        end
        if (n > MAX_PARTIES)
        begin
            n = MAX_PARTIES;
        end
        return n;
    endfunction

    // Takes one accepted vote item. Items before the last party are only
    // stored. The last party's item runs the highest-averages allocation with
    // its own quota, folds the district into the national counters and queues
    // one expected result per party.
    function automatic void allot_ballot(input logic [VOTE_W-1:0] votes,
                                         input logic [SEAT_W-1:0] quota);
        int                n;
        int                pos;
        int                s;
        int                i;
        int                winner;
        int                leader;
        logic              exhausted;
        logic [VOTE_W-1:0] best;
        logic [CNT_W:0]    seat_sum;
        logic [TVOTE_W:0]  vote_sum;
        party_tally_t      t;
        n   = live_parties(count_shadow);
        pos = (seat_position >= n) ? n - 1 : seat_position;
        dist_votes[pos] = votes;
        dist_quot[pos]  = votes;
        dist_seats[pos] = '0;
        if (pos + 1 < n)
        begin
            seat_position = pos + 1;
        end
        else
        begin
            seat_position = 0;
            exhausted     = 1'b0;
            // Seats go one at a time to the largest positive quotient, lowest
            // index on a tie. Once every quotient is zero the rest of the quota
            // is simply not awarded.
            for (s = 0; s < int'(quota) && !exhausted; s++)
            begin
                best   = '0;
                winner = -1;
                for (i = 0; i < n; i++)
                begin
                    if (dist_quot[i] > best)
                    begin
                        best   = dist_quot[i];
                        winner = i;
                    end
                end
                if (winner < 0)
                begin
                    exhausted = 1'b1;
                end
                else
                begin
                    dist_seats[winner] = dist_seats[winner] + 1'b1;
                    dist_quot[winner]  = dist_quot[winner] >> 1;
                end
            end
            // District leader by raw votes; with all votes zero this stays
            // party 0.
            leader = 0;
            for (i = 1; i < n; i++)
            begin
                if (dist_votes[i] > dist_votes[leader])
                begin
                    leader = i;
                end
            end
            for (i = 0; i < n; i++)
            begin
                vote_sum     = {1'b0, nat_votes[i]} + dist_votes[i];
                nat_votes[i] = vote_sum[TVOTE_W] ? '1 : vote_sum[TVOTE_W-1:0];
                seat_sum     = {1'b0, nat_seats[i]} + dist_seats[i];
                nat_seats[i] = seat_sum[CNT_W] ? '1 : seat_sum[CNT_W-1:0];
                if (i == leader && nat_firsts[i] != '1)
                begin
                    nat_firsts[i] = nat_firsts[i] + 1'b1;
                end
                if (dist_seats[i] == '0 && nat_noseat[i] != '1)
                begin
                    nat_noseat[i] = nat_noseat[i] + 1'b1;
                end
                t.party       = IDX_W'(i);
                t.seats       = dist_seats[i];
                t.total_seats = nat_seats[i];
                t.total_votes = nat_votes[i];
                t.firsts      = nat_firsts[i];
                t.no_seat     = nat_noseat[i];
                t.last        = (i + 1 == n);
                due_tallies.push_back(t);
            end
        end
    endfunction

    // Vote counts lean toward the interesting corners: zero, the maximum, a
    // tie with the previous party and small counts that run out of halvings.
    function automatic logic [VOTE_W-1:0] draw_votes(input logic [VOTE_W-1:0] prev);
        logic [VOTE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = prev;
            3, 4, 5: v = VOTE_W'($urandom_range(0, 1000));
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Large quotas with many parties make a district's allocation long, so most
    // districts keep the quota small and only a few go to the full range.
    function automatic logic [SEAT_W-1:0] draw_quota();
        logic [SEAT_W-1:0] q;
        if ($urandom_range(0, 19) == 0)
        begin
            q = SEAT_W'($urandom_range(0, 255));
        end
        else
        begin
            q = SEAT_W'($urandom_range(0, 12));
        end
        return q;
    endfunction

    // Vote source. The driver keeps valid up until the transfer, then either
    // loads the next pending item or goes idle. Register writes are mirrored
    // here too, at the edge where the block takes them.
    always @(posedge clk)
    begin : ballot_driver
        ballot_t next_ballot;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_PARTY_COUNT)
            begin
                count_shadow  = pwdata[COUNT_W-1:0];
                seat_position = 0;
            end
            if (item_valid && item_ch.ready)
            begin
                allot_ballot(item_votes, item_quota);
            end
            if (!item_valid || item_ch.ready)
            begin
                if (ballot_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_ballot = ballot_queue.pop_front();
                    item_valid <= 1'b1;
                    item_votes <= next_ballot.votes;
                    item_quota <= next_ballot.quota;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            result_errors++;
        end
    endtask

    // Result sink. Ready is redrawn every cycle; each result transfer is
    // checked field by field against the oldest expected party result.
    always @(posedge clk)
    begin : tally_monitor
        party_tally_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (result_ch.valid && res_ready)
            begin
                if (due_tallies.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual party %0d",
                             $time, result_ch.party_index);
                    result_errors++;
                end
                else
                begin
                    want = due_tallies.pop_front();
                    check_field("party_index", want.party, result_ch.party_index);
                    check_field("seats_won", want.seats, result_ch.seats_won);
                    check_field("total_seats", want.total_seats, result_ch.total_seats);
                    check_field("total_votes", want.total_votes, result_ch.total_votes);
                    check_field("districts_first", want.firsts, result_ch.districts_first);
                    check_field("districts_no_seat", want.no_seat,
                                result_ch.districts_no_seat);
                    check_field("last_result", want.last, result_ch.last_result);
                end
            end
        end
    end

    // Watchdog: any transfer on either channel or the bus resets the count.
    always @(posedge clk)
    begin
        if ((item_valid && item_ch.ready) || (result_ch.valid && res_ready) ||
            (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One bus access: setup phase, then access phase until pready. Read data
    // is taken at the edge that completes the access.
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads the party count back; it must hold the last written six bits.
    task automatic expect_party_count(input logic [COUNT_W-1:0] want);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, ADDR_PARTY_COUNT, '0, rd);
        if (rd != PDATA_W'(want))
        begin
            $display("%0t: party_count readback mismatch, expected %0h, actual %0h",
                     $time, want, rd);
            register_errors++;
        end
    endtask

    // Random upper data bits must be dropped by the six-bit register.
    task automatic write_party_count(input logic [COUNT_W-1:0] count);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, ADDR_PARTY_COUNT,
                   ($urandom() & ~PDATA_W'(6'h3F)) | PDATA_W'(count), rd);
        expect_party_count(count);
    endtask

    // Waits at falling edges until every pending item has gone in and every
    // expected result has come out.
    task automatic wait_drained();
        @(negedge clk);
        while (ballot_queue.size() != 0 || item_valid || due_tallies.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [PDATA_W-1:0] rd;
        logic [VOTE_W-1:0]  prev;
        ballot_t            b;
        int                 phase_no;
        int                 n;
        int                 d;
        int                 p;
        int                 k;
        int                 cfg;
        int                 preset_counts [7];
        ballot_t            opening [12];

        // Register settings for the first phases: below, at and above the
        // legal range, the full six-bit value, then ordinary counts.
        preset_counts = '{0, 1, 32, 63, 33, 3, 17};

        // Two-party districts with the reset count: maximum votes tied with a
        // full quota, so the halvings run out before the seats do; all votes
        // zero, where party 0 still leads; a zero quota; alternating bit
        // patterns; a quota on the first item that must be ignored; small
        // counts that tie on halved quotients; a party with no votes at all.
        opening = '{
            {32'hFFFF_FFFF, 8'h00}, {32'hFFFF_FFFF, 8'hFF},
            {32'h0000_0000, 8'hFF}, {32'h0000_0000, 8'hFF},
            {32'h0000_0005, 8'hFF}, {32'h0000_0007, 8'h00},
            {32'hAAAA_AAAA, 8'h55}, {32'h5555_5555, 8'hAA},
            {32'h0000_0001, 8'hC8}, {32'h0000_0003, 8'h05},
            {32'h0000_0000, 8'h03}, {32'h0000_0009, 8'h01}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        expect_party_count(PARTY_COUNT_RESET);

        @(negedge clk);
        for (k = 0; k < 12; k++)
        begin
            ballot_queue.push_back(opening[k]);
        end
        wait_drained();

        // A district cut short: one item goes in, then the next register
        // write must drop it and restart at party 0.
        @(negedge clk);
        ballot_queue.push_back({32'd123, 8'd7});
        wait_drained();

        phase_no = 0;
        while (phase_no < 7 || random_items < RANDOM_ITEMS)
        begin
            cfg = (phase_no < 7) ? preset_counts[phase_no] : $urandom_range(0, 63);
            // An item that ends no district leaves no result to wait for, so
            // give the block time before touching the register.
            repeat (16) @(posedge clk);
            write_party_count(COUNT_W'(cfg));
            if (phase_no == 1)
            begin
                // Register 1 does not exist; the count must survive the write.
                apb_access(1'b1, ADDR_UNMAPPED, $urandom(), rd);
                expect_party_count(COUNT_W'(cfg));
            end
            n = live_parties(COUNT_W'(cfg));

            @(negedge clk);
            case (phase_no % 4)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 79; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin sender_idle_pct = 12; sink_stall_pct = 12; end
            endcase

            // Complete districts with random content; now and then a party with
            // zero votes.
            for (d = 0; d < 1 + 24 / n; d++)
            begin
                prev = $urandom();
                for (p = 0; p < n; p++)
                begin
                    b.votes = ($urandom_range(0, 15) == 0) ? '0 : draw_votes(prev);
                    b.quota = draw_quota();
                    prev    = b.votes;
                    ballot_queue.push_back(b);
                    random_items++;
                end
            end
            // Sometimes the phase ends in the middle of a district, which the
            // next register write discards.
            if ($urandom_range(0, 1) == 1)
            begin
                prev = $urandom();
                for (p = 0; p < $urandom_range(1, n - 1); p++)
                begin
                    b.votes = draw_votes(prev);
                    b.quota = draw_quota();
                    prev    = b.votes;
                    ballot_queue.push_back(b);
                    random_items++;
                end
            end
            wait_drained();
            phase_no++;
        end

        // Let any stray result show up before the verdict.
        repeat (64) @(posedge clk);
        if (result_errors == 0 && register_errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
